@@ src/ycc2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// ycc2rgb_pkg: shared constants and types of the YCbCr to RGB pixel core
// Fixed-point formats, Rec.709 inverse matrix coefficients, component
// indexes and configuration register codes.
// ----------------------------------------------------------------------------
package ycc2rgb_pkg;

	// default code width of the pixel ports
	localparam int IN_WIDTH_DEF = 12;

	// legal range of the configured code depth
	localparam int DEPTH_MIN = 8;
	localparam int DEPTH_CAP = 12;
	localparam int DEPTH_W   = 4;

	// fractional bits of normalized values and of the coefficients
	localparam int FRAC  = 24;
	localparam int CFRAC = 20;

	// result width and full-scale codes
	localparam int OUT_W = 16;
	localparam logic [OUT_W-1:0] FULL_NARROW = 16'h00FF;
	localparam logic [OUT_W-1:0] FULL_WIDE   = 16'hFFFF;
	localparam int SHIFT_NARROW = 8;
	localparam int SHIFT_WIDE   = 16;

	// offsets and rounding constants
	localparam int OFS_LUMA   = 1 << (FRAC - 4);
	localparam int OFS_CHROMA = 1 << (FRAC - 1);
	localparam int RND_ACC    = 1 << (CFRAC - 1);
	localparam int RND_OUT    = 1 << (FRAC - 1);

	// component lanes, input side and result side
	localparam int NUM_COMP = 3;
	localparam int COMP_Y   = 0;
	localparam int COMP_CB  = 1;
	localparam int COMP_CR  = 2;
	localparam int RGB_R    = 0;
	localparam int RGB_G    = 1;
	localparam int RGB_B    = 2;

	// Rec.709 inverse matrix in signed Q3.20
	localparam int COEF_W = 23;
	localparam logic signed [COEF_W-1:0] C_Y  = 23'sd1220945;
	localparam logic signed [COEF_W-1:0] C_RV = 23'sd1879825;
	localparam logic signed [COEF_W-1:0] C_GU = 23'sd223607;
	localparam logic signed [COEF_W-1:0] C_GV = 23'sd558796;
	localparam logic signed [COEF_W-1:0] C_BU = 23'sd2215014;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INPUT_BITS  = 2'd0,
		REG_OUTPUT_WIDE = 2'd1
	} cfg_reg_t;

endpackage

@@ src/ycc2rgb_norm.sv @@
// ----------------------------------------------------------------------------
// ycc2rgb_norm: pipelined normalization of three codes by 2^b - 1
// Computes round(code * 2^24 / (2^b - 1)) for each lane. Since 2^b is one
// modulo the divisor, each stage folds the high part of the remainder onto
// the low part and adds it to the quotient; a final compare corrects by one.
// ----------------------------------------------------------------------------
module ycc2rgb_norm #(
	parameter int IN_WIDTH = ycc2rgb_pkg::IN_WIDTH_DEF,
	parameter int STEPS    = (IN_WIDTH + ycc2rgb_pkg::FRAC + 7) / 7 + 1
) (
	input  logic                                                      clk,
	input  logic                                                      arst_n,
	input  logic                                                      in_valid,
	input  logic [ycc2rgb_pkg::NUM_COMP-1:0][IN_WIDTH-1:0]            code,
	input  logic [ycc2rgb_pkg::DEPTH_W-1:0]                           depth,
	output logic                                                      out_valid,
	output logic [ycc2rgb_pkg::NUM_COMP-1:0][IN_WIDTH+ycc2rgb_pkg::FRAC-8:0] norm
);
	import ycc2rgb_pkg::*;

	localparam int XW = IN_WIDTH + FRAC + 1;
	localparam int QW = IN_WIDTH + FRAC - 7;
	localparam int MW = DEPTH_CAP;

	logic [MW-1:0] m_c;
	logic [MW-1:0] h_c;
	logic [XW-1:0] m_x;

	logic [STEPS+1:0]              vld_s;
	logic [NUM_COMP-1:0][XW-1:0]   x_s [STEPS+1];
	logic [NUM_COMP-1:0][QW-1:0]   q_s [STEPS+1];
	logic [NUM_COMP-1:0][QW-1:0]   n_s;

	// divisor and half divisor for rounding
	always_comb begin
		m_c = (MW'(1) << depth) - MW'(1);
		h_c = m_c >> 1;
		m_x = XW'(m_c);
	end

	// valid bits travel alongside the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[STEPS:0], in_valid};
		end
	end

	// entry stage: scaled code plus rounding term
	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_COMP; l++) begin
			x_s[0][l] <= {1'b0, code[l], {FRAC{1'b0}}} + XW'(h_c);
			q_s[0][l] <= '0;
		end
	end

	// folding stages: x = hi * 2^b + lo gives quotient hi plus (hi + lo) / m
	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic [NUM_COMP-1:0][XW-1:0] hi_c;
		logic [NUM_COMP-1:0][XW-1:0] lo_c;

		always_comb begin
			for (int l = 0; l < NUM_COMP; l++) begin
				hi_c[l] = x_s[k-1][l] >> depth;
				lo_c[l] = x_s[k-1][l] & m_x;
			end
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < NUM_COMP; l++) begin
				x_s[k][l] <= hi_c[l] + lo_c[l];
				q_s[k][l] <= q_s[k-1][l] + hi_c[l][QW-1:0];
			end
		end
	end

	// last correction: remainder is now below twice the divisor
	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_COMP; l++) begin
			n_s[l] <= q_s[STEPS][l] + QW'(x_s[STEPS][l] >= m_x);
		end
	end

	assign out_valid = vld_s[STEPS+1];
	assign norm      = n_s;

endmodule

@@ src/ycbcr709_to_rgb_pixel_core.sv @@
// ----------------------------------------------------------------------------
// ycbcr709_to_rgb_pixel_core: limited-range Rec.709 YCbCr to RGB converter
// Normalizes each code by its full scale, removes the video offsets, applies
// the inverse matrix in fixed point and rounds and clamps to 8 or 16 bits.
// ----------------------------------------------------------------------------
// One pixel is accepted in every clock cycle: busy never rises, so start may
// stay high for a whole line. Each result appears on red, green and blue for
// one cycle with done high. Its path runs through the entry stage, the folding
// stages and the final correction of the normalizer, and the matrix, rounding
// and clamp add four more stages. Results cannot be held off and must be
// taken as they come. Configuration writes are taken in any cycle (cfg_ready
// is always high) but belong in gaps between pixels with the pipeline
// drained. input_bits is clamped to 8 and to min(IN_WIDTH, 12).
module ycbcr709_to_rgb_pixel_core #(
	parameter int IN_WIDTH = ycc2rgb_pkg::IN_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [IN_WIDTH-1:0]                luma,
	input  logic [IN_WIDTH-1:0]                chroma_blue,
	input  logic [IN_WIDTH-1:0]                chroma_red,
	output logic                               done,
	output logic [ycc2rgb_pkg::OUT_W-1:0]      red,
	output logic [ycc2rgb_pkg::OUT_W-1:0]      green,
	output logic [ycc2rgb_pkg::OUT_W-1:0]      blue,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ycc2rgb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ycc2rgb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ycc2rgb_pkg::*;

	localparam int DEPTH_MAX  = (IN_WIDTH < DEPTH_CAP) ? IN_WIDTH : DEPTH_CAP;
	localparam int NORM_STEPS = (IN_WIDTH + FRAC + 7) / 7 + 1;
	localparam int LATENCY    = NORM_STEPS + 6;
	localparam int QW         = IN_WIDTH + FRAC - 7;
	localparam int NS         = QW + 1;
	localparam int PW         = NS + COEF_W;
	localparam int AW         = PW + 2;
	localparam int A2W        = AW - CFRAC;
	localparam int TW         = A2W + OUT_W + 1;
	localparam int OW         = TW - FRAC;

	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] depth_c;
	logic               wide_q;

	logic [NUM_COMP-1:0][IN_WIDTH-1:0] code_c;
	logic [NUM_COMP-1:0][QW-1:0]       n_c;
	logic                              n_vld;

	logic signed [NS-1:0] y_c;
	logic signed [NS-1:0] u_c;
	logic signed [NS-1:0] v_c;

	logic                 vld_s1;
	logic signed [PW-1:0] py_s1;
	logic signed [PW-1:0] prv_s1;
	logic signed [PW-1:0] pgu_s1;
	logic signed [PW-1:0] pgv_s1;
	logic signed [PW-1:0] pbu_s1;

	logic signed [AW-1:0]  acc_c [NUM_COMP];
	logic                  vld_s2;
	logic signed [A2W-1:0] a_s2 [NUM_COMP];

	logic signed [TW-1:0]  ext_c [NUM_COMP];
	logic signed [TW-1:0]  t_c [NUM_COMP];
	logic                  vld_s3;
	logic signed [OW-1:0]  o_s3 [NUM_COMP];

	logic [OUT_W-1:0]      full_c;
	logic signed [OW-1:0]  full_x;
	logic [OUT_W-1:0]      res_c [NUM_COMP];
	logic [OUT_W-1:0]      rgb_q [NUM_COMP];
	logic                  done_q;

	// configuration: depth is stored already clamped to its legal range
	always_comb begin
		if (cfg_data < DEPTH_W'(DEPTH_MIN)) begin
			depth_c = DEPTH_W'(DEPTH_MIN);
		end else if (cfg_data > DEPTH_W'(DEPTH_MAX)) begin
			depth_c = DEPTH_W'(DEPTH_MAX);
		end else begin
			depth_c = DEPTH_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_W'(DEPTH_MIN);
			wide_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INPUT_BITS:  depth_q <= depth_c;
				REG_OUTPUT_WIDE: wide_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// normalization of the three codes
	assign code_c[COMP_Y]  = luma;
	assign code_c[COMP_CB] = chroma_blue;
	assign code_c[COMP_CR] = chroma_red;

	ycc2rgb_norm #(
		.IN_WIDTH (IN_WIDTH),
		.STEPS    (NORM_STEPS)
	) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.code      (code_c),
		.depth     (depth_q),
		.out_valid (n_vld),
		.norm      (n_c)
	);

	// offset removal
	always_comb begin
		y_c = $signed({1'b0, n_c[COMP_Y]})  - NS'(OFS_LUMA);
		u_c = $signed({1'b0, n_c[COMP_CB]}) - NS'(OFS_CHROMA);
		v_c = $signed({1'b0, n_c[COMP_CR]}) - NS'(OFS_CHROMA);
	end

	// stage 1: matrix products
	always_ff @(posedge clk) begin
		py_s1  <= PW'(y_c) * PW'(C_Y);
		prv_s1 <= PW'(v_c) * PW'(C_RV);
		pgu_s1 <= PW'(u_c) * PW'(C_GU);
		pgv_s1 <= PW'(v_c) * PW'(C_GV);
		pbu_s1 <= PW'(u_c) * PW'(C_BU);
	end

	// stage 2: row sums, rounded half up to 24 fractional bits
	always_comb begin
		acc_c[RGB_R] = AW'(py_s1) + AW'(prv_s1) + AW'(RND_ACC);
		acc_c[RGB_G] = AW'(py_s1) - AW'(pgu_s1) - AW'(pgv_s1) + AW'(RND_ACC);
		acc_c[RGB_B] = AW'(py_s1) + AW'(pbu_s1) + AW'(RND_ACC);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_COMP; i++) begin
			a_s2[i] <= acc_c[i][AW-1:CFRAC];
		end
	end

	// stage 3: scale by full scale as shift minus value, round half up
	always_comb begin
		for (int i = 0; i < NUM_COMP; i++) begin
			ext_c[i] = TW'(a_s2[i]);
			t_c[i]   = (wide_q ? (ext_c[i] <<< SHIFT_WIDE) : (ext_c[i] <<< SHIFT_NARROW))
				- ext_c[i] + TW'(RND_OUT);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_COMP; i++) begin
			o_s3[i] <= t_c[i][TW-1:FRAC];
		end
	end

	// clamp to zero and full scale
	always_comb begin
		full_c = wide_q ? FULL_WIDE : FULL_NARROW;
		full_x = OW'($signed({1'b0, full_c}));
		for (int i = 0; i < NUM_COMP; i++) begin
			if (o_s3[i] < 0) begin
				res_c[i] = '0;
			end else if (o_s3[i] > full_x) begin
				res_c[i] = full_c;
			end else begin
				res_c[i] = o_s3[i][OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_COMP; i++) begin
			rgb_q[i] <= res_c[i];
		end
	end

	// valid chain of the matrix stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= n_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	assign done  = done_q;
	assign red   = rgb_q[RGB_R];
	assign green = rgb_q[RGB_G];
	assign blue  = rgb_q[RGB_B];

`ifndef ASSERT_OFF
	// every accepted transaction yields its result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after accepted transaction");

	// no result without a transaction accepted a latency earlier
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without accepted transaction");

	// narrow mode results stay within 8 bits
	a_narrow_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(wide_q)) |->
		(red[OUT_W-1:SHIFT_NARROW] == '0 && green[OUT_W-1:SHIFT_NARROW] == '0 &&
		 blue[OUT_W-1:SHIFT_NARROW] == '0))
		else $error("narrow result above full scale");

	// stored depth always within the supported range
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		(depth_q >= DEPTH_W'(DEPTH_MIN) && depth_q <= DEPTH_W'(DEPTH_MAX)))
		else $error("depth register out of range");
`endif

endmodule

@@ tb/ycbcr709_to_rgb_pixel_core_tb.sv @@
// ----------------------------------------------------------------------------
// ycbcr709_to_rgb_pixel_core_tb: self-checking bench of the YCbCr to RGB core
// Sends directed and random pixels at several code depths and both output
// scales. A fixed-point model in the bench predicts each RGB result, and
// every strobed result is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module ycbcr709_to_rgb_pixel_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ycc2rgb_pkg::*;

	localparam int IN_W        = IN_WIDTH_DEF;
	localparam int PIPE_LAT    = (IN_W + 31) / 7 + 7;
	localparam int MAX_GAP     = 10;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_LIMIT = 2000;
	localparam int PHASE_PIXELS = 48;
	localparam longint TIMEOUT_NS = 2_000_000;

	// register indexes past the end of the register list
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// Rec.709 inverse matrix, Q3.20
	localparam longint K_LUMA  = 1220945;
	localparam longint K_R_CR  = 1879825;
	localparam longint K_G_CB  = 223607;
	localparam longint K_G_CR  = 558796;
	localparam longint K_B_CB  = 2215014;
	localparam int     NORM_FRAC = 24;
	localparam int     COEF_FRAC = 20;

	typedef struct {
		logic [IN_W-1:0]  y;
		logic [IN_W-1:0]  cb;
		logic [IN_W-1:0]  cr;
		logic [OUT_W-1:0] r;
		logic [OUT_W-1:0] g;
		logic [OUT_W-1:0] b;
	} pixel_rec_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [IN_W-1:0]       luma;
	logic [IN_W-1:0]       chroma_blue;
	logic [IN_W-1:0]       chroma_red;
	logic                  done;
	logic [OUT_W-1:0]      red;
	logic [OUT_W-1:0]      green;
	logic [OUT_W-1:0]      blue;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// bench copy of the configuration registers
	logic [DEPTH_W-1:0] depth_cfg;
	logic               wide_cfg;

	pixel_rec_t pending_rgb[$];
	int pixels_sent;
	int results_seen;
	int mismatch_count;
	int settings_used;

	ycbcr709_to_rgb_pixel_core #(
		.IN_WIDTH(IN_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.luma(luma),
		.chroma_blue(chroma_blue),
		.chroma_red(chroma_red),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// fixed-point model of the converter
	// ------------------------------------------------------------------

	// depth register as the core uses it
	function automatic int unsigned depth_in_use(input logic [DEPTH_W-1:0] depth_reg);
		int unsigned d;
		d = 32'(depth_reg);
		if (d < 8)
			d = 8;
		if (d > 12)
			d = 12;
		return d;
	endfunction

	// code scaled to a fraction with 24 fractional bits, nearest
	function automatic longint norm_code(input logic [IN_W-1:0] code, input longint m);
		return ((longint'(code) << NORM_FRAC) + (m >> 1)) / m;
	endfunction

	// matrix sum down to the output scale, half up, clamped
	function automatic logic [OUT_W-1:0] scale_and_clamp(input longint acc, input longint fs);
		longint a24;
		longint o;
		a24 = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
		o = (a24 * fs + (longint'(1) << (NORM_FRAC - 1))) >>> NORM_FRAC;
		if (o < 0)
			o = 0;
		if (o > fs)
			o = fs;
		return o[OUT_W-1:0];
	endfunction

	function automatic pixel_rec_t rgb_from_ycc(input logic [IN_W-1:0] y_code,
			input logic [IN_W-1:0] cb_code, input logic [IN_W-1:0] cr_code);
		pixel_rec_t rec;
		longint m;
		longint fs;
		longint ny;
		longint nu;
		longint nv;
		m = (longint'(1) << depth_in_use(depth_cfg)) - 1;
		fs = wide_cfg ? longint'(65535) : longint'(255);
		ny = norm_code(y_code, m) - (longint'(1) << (NORM_FRAC - 4));
		nu = norm_code(cb_code, m) - (longint'(1) << (NORM_FRAC - 1));
		nv = norm_code(cr_code, m) - (longint'(1) << (NORM_FRAC - 1));
		rec.y = y_code;
		rec.cb = cb_code;
		rec.cr = cr_code;
		rec.r = scale_and_clamp(K_LUMA * ny + K_R_CR * nv, fs);
		rec.g = scale_and_clamp(K_LUMA * ny - K_G_CB * nu - K_G_CR * nv, fs);
		rec.b = scale_and_clamp(K_LUMA * ny + K_B_CB * nu, fs);
		return rec;
	endfunction

	// ------------------------------------------------------------------
	// shared tasks
	// ------------------------------------------------------------------

	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// one pixel transaction, entered and left at a falling edge
	task automatic send_pixel(input logic [IN_W-1:0] y_code, input logic [IN_W-1:0] cb_code,
			input logic [IN_W-1:0] cr_code, input int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		luma = y_code;
		chroma_blue = cb_code;
		chroma_red = cr_code;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_rgb.push_back(rgb_from_ycc(y_code, cb_code, cr_code));
		pixels_sent++;
		@(negedge clk);
	endtask

	// hold off until every predicted result has come back
	task automatic drain_pipeline();
		int waited;
		waited = 0;
		start = 1'b0;
		while (pending_rgb.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (PIPE_LAT + 2) @(negedge clk);
	endtask

	// register write transaction, only with the pipeline empty
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain_pipeline();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		case (idx)
			REG_INPUT_BITS: depth_cfg = data;
			REG_OUTPUT_WIDE: wide_cfg = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int draw_gap();
		return $urandom_range(MAX_GAP, 0);
	endfunction

	// mostly codes within full scale, some extremes and some above it
	function automatic logic [IN_W-1:0] draw_code();
		int unsigned full_code;
		full_code = (1 << depth_in_use(depth_cfg)) - 1;
		case ($urandom_range(7, 0))
			0: return IN_W'($urandom_range((1 << IN_W) - 1, 0));
			1: return ($urandom_range(1, 0) != 0) ? IN_W'(full_code) : '0;
			default: return IN_W'($urandom_range(full_code, 0));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		pixel_rec_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (pending_rgb.size() == 0) begin
				note_failure($sformatf("unexpected result r=%0d g=%0d b=%0d", red, green, blue));
			end else begin
				want = pending_rgb.pop_front();
				if (red !== want.r || green !== want.g || blue !== want.b)
					note_failure($sformatf(
						"mismatch ycc=(%0d,%0d,%0d) exp rgb=(%0d,%0d,%0d) got (%0d,%0d,%0d)",
						want.y, want.cb, want.cr, want.r, want.g, want.b, red, green, blue));
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset setting: 8-bit codes, 8-bit output
	task automatic test_reset_setting();
		settings_used++;
		send_pixel(12'd16, 12'd128, 12'd128, draw_gap());
		send_pixel(12'd235, 12'd128, 12'd128, 0);
		send_pixel(12'd0, 12'd0, 12'd0, 0);
		send_pixel(12'd255, 12'd255, 12'd255, draw_gap());
		send_pixel(12'd128, 12'd0, 12'd255, 0);
		send_pixel(12'd128, 12'd255, 12'd0, draw_gap());
	endtask

	// deepest codes at the wide scale, then codes above full scale
	task automatic test_field_extremes();
		write_reg(REG_INPUT_BITS, 4'd12);
		write_reg(REG_OUTPUT_WIDE, 4'b1111);
		settings_used++;
		send_pixel(12'd256, 12'd2048, 12'd2048, 0);
		send_pixel(12'd3760, 12'd2048, 12'd2048, 0);
		send_pixel(12'd0, 12'd0, 12'd0, draw_gap());
		send_pixel(12'hFFF, 12'hFFF, 12'hFFF, 0);
		send_pixel(12'd2048, 12'd3840, 12'd256, draw_gap());
		send_pixel(12'd2048, 12'd256, 12'd3840, 0);
		write_reg(REG_INPUT_BITS, 4'd8);
		settings_used++;
		send_pixel(12'hFFF, 12'd0, 12'hFFF, 0);
		send_pixel(12'd300, 12'hFFF, 12'd0, 0);
	endtask

	// depth values outside 8..12 act as the nearest bound
	task automatic test_depth_clamp();
		write_reg(REG_OUTPUT_WIDE, 4'b0000);
		write_reg(REG_INPUT_BITS, 4'd0);
		settings_used++;
		send_pixel(12'd235, 12'd240, 12'd16, 0);
		write_reg(REG_INPUT_BITS, 4'd15);
		settings_used++;
		send_pixel(12'd3760, 12'd3840, 12'd256, 0);
	endtask

	// writes to indexes past the register list change nothing
	task automatic test_spare_index();
		write_reg(REG_SPARE_A, 4'hF);
		write_reg(REG_SPARE_B, 4'hA);
		send_pixel(12'd1000, 12'd3000, 12'd500, 0);
		send_pixel(12'd4000, 12'd100, 12'd3900, draw_gap());
	endtask

	// random pixels over a list of settings, with varied idling
	task automatic test_random_phases();
		logic [DEPTH_W-1:0] depth_list[10];
		logic               wide_list[10];
		int                 idle_mode;
		int                 gap;
		depth_list = '{4'd8, 4'd12, 4'd10, 4'd9, 4'd11, 4'd12, 4'd8, 4'd0, 4'd15, 4'd10};
		wide_list = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		for (int p = 0; p < 10; p++) begin
			write_reg(REG_INPUT_BITS, depth_list[p]);
			write_reg(REG_OUTPUT_WIDE, {3'($urandom_range(7, 0)), wide_list[p]});
			if ($urandom_range(2, 0) == 0)
				write_reg($urandom_range(1, 0) ? REG_SPARE_A : REG_SPARE_B,
					4'($urandom_range(15, 0)));
			settings_used++;
			idle_mode = p % 3;
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				case (idle_mode)
					0: gap = 0;
					1: gap = draw_gap();
					default: gap = ($urandom_range(3, 0) == 0) ? draw_gap() : 0;
				endcase
				// let the whole pipeline empty out midway through some phases
				if (idle_mode == 1 && i == PHASE_PIXELS / 2)
					drain_pipeline();
				send_pixel(draw_code(), draw_code(), draw_code(), gap);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int waited;
		arst_n = 1'b0;
		start = 1'b0;
		luma = '0;
		chroma_blue = '0;
		chroma_red = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_INPUT_BITS;
		cfg_data = '0;
		depth_cfg = 4'd8;
		wide_cfg = 1'b0;
		pixels_sent = 0;
		results_seen = 0;
		mismatch_count = 0;
		settings_used = 0;
		waited = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_setting();
		test_field_extremes();
		test_depth_clamp();
		test_spare_index();
		test_random_phases();

		// wait for the last results, then watch for strays
		start = 1'b0;
		while (pending_rgb.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (PIPE_LAT + 4) @(negedge clk);
		if (pending_rgb.size() != 0)
			note_failure($sformatf("%0d results never arrived", pending_rgb.size()));

		$display("converted %0d pixels over %0d register settings, depths 8 to 12 and both scales",
			pixels_sent, settings_used);
		$display("%0d results checked, %0d failures", results_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
